@@ src/kct_pkg.sv @@
// kct_pkg: shared codes and fixed field widths for the keyed count table
// no dependencies

package kct_pkg;

  localparam int ACTION_W    = 2;
  localparam int IN_KEY_W    = 32;
  localparam int AMOUNT_W    = 16;
  localparam int STATUS_W    = 2;
  localparam int OUT_COUNT_W = 16;

  localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CONSUME = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

@@ src/kct_ram.sv @@
// kct_ram: generic simple dual-port ram, one write and one read port
// read data is registered; no dependencies

module kct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/keyed_count_table.sv @@
// keyed_count_table: one request at a time, taken only in the idle state. a linear search
// reads one table entry per cycle from the ram, then a tail state and a decide state follow;
// the decide state registers the result and waits while the previous result is still held.
// after reset a clearing pass writes every entry invalid; no request is taken during it.
// authority_enable resets to 1.
// depends on kct_pkg and kct_ram

module keyed_count_table
  import kct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int KEY_BITS      = 32,
  parameter int COUNT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,    // authority_enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,      // item_key[31:0], amount[47:32]
  input  logic [1:0]  s_tuser,      // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // count[15:0]
  output logic [2:0]  m_tuser       // status[1:0], changed[2]
);

  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int SUM_W  = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_ENTRIES - 1);
  localparam logic [SUM_W-1:0] COUNT_MAX =
    {{(SUM_W - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

  typedef struct packed {
    logic                  vld;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DECIDE
  } state_t;

  state_t state;

  logic                     authority_enable;
  logic [ADDR_W-1:0]        idx;
  logic                     pend;
  logic [ADDR_W-1:0]        pend_idx;

  logic [ACTION_W-1:0]      action;
  logic [KEY_BITS-1:0]      key;
  logic [AMOUNT_W-1:0]      amount;

  logic                     hit;
  logic [ADDR_W-1:0]        hit_slot;
  logic [COUNT_BITS-1:0]    hit_count;
  logic                     free_found;
  logic [ADDR_W-1:0]        free_slot;

  entry_t                   rd_entry;
  entry_t                   wr_entry;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;

  // decision outcome
  status_t                  dec_status;
  logic [SUM_W-1:0]         dec_count;
  logic                     dec_changed;
  logic                     dec_we;
  logic [ADDR_W-1:0]        dec_slot;
  entry_t                   dec_entry;

  logic [SUM_W-1:0]         cur;
  logic [SUM_W-1:0]         amt;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-1:0]         sum_sat;
  logic [SUM_W-1:0]         amt_sat;
  logic [SUM_W-1:0]         diff;
  logic                     out_free;
  logic                     hit_now;
  logic                     free_now;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign hit_now  = pend && rd_entry.vld && (rd_entry.key == key) && (key != '0);
  assign free_now = pend && !rd_entry.vld && !free_found;

  always_comb begin
    cur     = hit ? SUM_W'(hit_count) : '0;
    amt     = SUM_W'(amount);
    sum     = cur + amt;
    sum_sat = (sum > COUNT_MAX) ? COUNT_MAX : sum;
    amt_sat = (amt > COUNT_MAX) ? COUNT_MAX : amt;
    diff    = cur - amt;

    dec_status  = ST_OK;
    dec_count   = cur;
    dec_changed = 1'b0;
    dec_we      = 1'b0;
    dec_slot    = hit_slot;
    dec_entry   = '{vld: 1'b1, key: key, cnt: cur[COUNT_BITS-1:0]};

    if (action == ACT_QUERY) begin
      dec_status = ST_OK;
    end else if ((action != ACT_ADD && action != ACT_CONSUME) || !authority_enable ||
                 amount == '0 || key == '0) begin
      dec_status = ST_REJECT;
    end else if (action == ACT_ADD) begin
      if (hit) begin
        dec_count     = sum_sat;
        dec_changed   = (sum_sat != cur);
        dec_we        = 1'b1;
        dec_entry.cnt = sum_sat[COUNT_BITS-1:0];
      end else if (free_found) begin
        dec_count     = amt_sat;
        dec_changed   = 1'b1;
        dec_we        = 1'b1;
        dec_slot      = free_slot;
        dec_entry.cnt = amt_sat[COUNT_BITS-1:0];
      end else begin
        dec_status = ST_FULL;
        dec_count  = '0;
      end
    end else begin
      if (!hit || cur < amt) begin
        dec_status = ST_MISSING;
      end else begin
        dec_count     = diff;
        dec_changed   = 1'b1;
        dec_we        = 1'b1;
        dec_entry.cnt = diff[COUNT_BITS-1:0];
        // slot is freed when it drains to zero
        dec_entry.vld = (diff != '0);
      end
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = idx;
      wr_entry  = '{vld: 1'b0, key: '0, cnt: '0};
    end else begin
      mem_we    = (state == S_DECIDE) && out_free && dec_we;
      mem_waddr = dec_slot;
      wr_entry  = dec_entry;
    end
  end

  kct_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_entry),
    .raddr (idx),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      idx              <= '0;
      pend             <= 1'b0;
      authority_enable <= 1'b1;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        authority_enable <= cfg_wdata;
      end
      // a new result loaded in S_DECIDE takes priority over the clear
      if (m_tvalid && m_tready && !(state == S_DECIDE && out_free)) begin
        m_tvalid <= 1'b0;
      end
      pend <= (state == S_SCAN);

      // collect the match and the lowest free slot as read data arrives
      if (hit_now) begin
        hit       <= 1'b1;
        hit_slot  <= pend_idx;
        hit_count <= rd_entry.cnt;
      end
      if (free_now) begin
        free_found <= 1'b1;
        free_slot  <= pend_idx;
      end

      case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            action     <= s_tuser[ACTION_W-1:0];
            key        <= KEY_BITS'(s_tdata[IN_KEY_W-1:0]);
            amount     <= s_tdata[IN_KEY_W +: AMOUNT_W];
            hit        <= 1'b0;
            free_found <= 1'b0;
            idx        <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_idx <= idx;
          if (idx == LAST_IDX) begin
            state <= S_TAIL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TAIL: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= dec_count[OUT_COUNT_W-1:0];
            m_tuser  <= {dec_changed, dec_status};
            idx      <= '0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
